>>> rtl/core/dttc_pkg.sv
// ----------------------------------------------------------------------------
// dttc_pkg
// Shared types and constants for the decimal text to cents parser.
// ----------------------------------------------------------------------------
package dttc_pkg;

   // width of the integer part accumulator; holds up to WHOLE_CAP
   localparam int WHOLE_W = 57;
   // width of the cent magnitude
   localparam int MAG_W   = 64;

   // largest integer part whose value times 100 still fits below 2^63
   localparam logic [WHOLE_W-1:0] WHOLE_CAP = 57'd92233720368547758;

   // result status codes
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_NOT_NUMBER   = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW     = 2'd2;
   localparam logic [1:0] STATUS_NEG_REJECTED = 2'd3;

   // parse snapshot taken at the end marker, passed to the finish stage
   typedef struct packed {
      logic             malformed;
      logic             overflow;
      logic             negative;
      logic [MAG_W-1:0] magnitude;
   } dttc_snap_type;

endpackage

>>> rtl/core/dttc_channels.sv
// ----------------------------------------------------------------------------
// dttc channels
// Valid/ready channels for text requests and cent results.
// ----------------------------------------------------------------------------
interface dttc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_char;
   logic       end_marker;

   modport source (output valid, output text_char, output end_marker, input ready);
   modport sink   (input valid, input text_char, input end_marker, output ready);
endinterface

interface dttc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] cents_value;
   logic [1:0]         parse_status;

   modport source (output valid, output cents_value, output parse_status, input ready);
   modport sink   (input valid, input cents_value, input parse_status, output ready);
endinterface

>>> rtl/core/dttc_parse.sv
// ----------------------------------------------------------------------------
// dttc_parse
// Per-character parse state and the snapshot register loaded on the end
// marker: sign, integer part, two fraction digits and the rounding decision.
// ----------------------------------------------------------------------------
module dttc_parse (
   input  logic                   clock,
   input  logic                   reset,
   dttc_req_if.sink               req,
   input  logic                   snap_ready,
   output logic                   snap_valid,
   output dttc_pkg::dttc_snap_type snap
);

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_SIGNED = 3'd1;
   localparam logic [2:0] PH_WHOLE  = 3'd2;
   localparam logic [2:0] PH_FRAC   = 3'd3;
   localparam logic [2:0] PH_BAD    = 3'd4;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   logic [2:0]                   phase_ff, phase_in;
   logic                         neg_ff, neg_in;
   logic [dttc_pkg::WHOLE_W-1:0] whole_ff, whole_in;
   logic [6:0]                   frac_ff, frac_in;
   logic [1:0]                   count_ff, count_in;
   logic                         round_ff, round_in;
   logic                         ovf_ff, ovf_in;
   logic                         snap_valid_ff, snap_valid_in;
   dttc_pkg::dttc_snap_type      snap_ff, snap_in;

   logic        accept;
   logic        is_digit;
   logic [3:0]  digit;
   logic [60:0] whole_x10;
   logic        whole_gt;
   logic [6:0]  frac_x10;
   logic [6:0]  frac_adj;
   logic        round_up;

   // take a request whenever the snapshot slot is free or moving on
   assign req.ready = !snap_valid_ff || snap_ready;
   assign accept    = req.valid && req.ready;

   assign is_digit = (req.text_char >= CHAR_ZERO) && (req.text_char <= CHAR_NINE);
   assign digit    = req.text_char[3:0];

   // integer part times ten plus the digit, and the cap check
   assign whole_x10 = {1'b0, whole_ff, 3'b000} + {3'b000, whole_ff, 1'b0}
                    + {57'd0, digit};
   assign whole_gt  = whole_x10 > {4'd0, dttc_pkg::WHOLE_CAP};

   assign frac_x10 = {frac_ff[3:0], 3'b000} + {frac_ff[5:0], 1'b0};

   // advance the parse state on each character
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      whole_in = whole_ff;
      frac_in  = frac_ff;
      count_in = count_ff;
      round_in = round_ff;
      ovf_in   = ovf_ff;
      if (accept && req.end_marker) begin
         phase_in = PH_START;
         neg_in   = 1'b0;
         whole_in = '0;
         frac_in  = '0;
         count_in = '0;
         round_in = 1'b0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         case (phase_ff)
            PH_START, PH_SIGNED, PH_WHOLE: begin
               if (phase_ff == PH_START &&
                   (req.text_char == CHAR_PLUS || req.text_char == CHAR_MINUS)) begin
                  neg_in   = (req.text_char == CHAR_MINUS);
                  phase_in = PH_SIGNED;
               end else if (is_digit) begin
                  if (ovf_ff || whole_gt) begin
                     ovf_in = 1'b1;
                  end else begin
                     whole_in = whole_x10[dttc_pkg::WHOLE_W-1:0];
                  end
                  phase_in = PH_WHOLE;
               end else if (req.text_char == CHAR_POINT && phase_ff == PH_WHOLE) begin
                  phase_in = PH_FRAC;
               end else begin
                  phase_in = PH_BAD;
               end
            end
            PH_FRAC: begin
               if (!is_digit) begin
                  phase_in = PH_BAD;
               end else if (count_ff < 2'd2) begin
                  frac_in  = frac_x10 + {3'b000, digit};
                  count_in = count_ff + 2'd1;
               end else if (count_ff == 2'd2) begin
                  round_in = (digit >= 4'd5);
                  count_in = 2'd3;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // scale the kept fraction digits to cents
   always_comb begin
      case (count_ff)
         2'd0:    frac_adj = '0;
         2'd1:    frac_adj = frac_x10;
         default: frac_adj = frac_ff;
      endcase
   end
   assign round_up = (count_ff == 2'd3) && round_ff;

   // build the snapshot: integer part times 100 plus fraction and rounding
   always_comb begin
      snap_in.malformed = (phase_ff != PH_WHOLE) && (phase_ff != PH_FRAC);
      snap_in.overflow  = ovf_ff;
      snap_in.negative  = neg_ff;
      snap_in.magnitude = {1'b0, whole_ff, 6'd0} + {2'd0, whole_ff, 5'd0}
                        + {5'd0, whole_ff, 2'd0} + {57'd0, frac_adj}
                        + {63'd0, round_up};
   end

   assign snap_valid_in = (!snap_valid_ff || snap_ready) ? (accept && req.end_marker)
                                                         : snap_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         neg_ff        <= 1'b0;
         whole_ff      <= '0;
         frac_ff       <= '0;
         count_ff      <= '0;
         round_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         whole_ff      <= whole_in;
         frac_ff       <= frac_in;
         count_ff      <= count_in;
         round_ff      <= round_in;
         ovf_ff        <= ovf_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // load the snapshot payload on an accepted end marker
   always_ff @(posedge clock) begin
      if (accept && req.end_marker) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

>>> rtl/core/dttc_finish.sv
// ----------------------------------------------------------------------------
// dttc_finish
// Range check, status and sign for one snapshot, into the result register.
// ----------------------------------------------------------------------------
module dttc_finish (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    reject_negative,
   input  logic                    snap_valid,
   input  dttc_pkg::dttc_snap_type snap,
   output logic                    snap_ready,
   dttc_rsp_if.source              rsp
);

   logic        out_valid_ff, out_valid_in;
   logic [63:0] cents_ff, cents_in;
   logic [1:0]  status_ff, status_in;
   logic        advance;
   logic        too_big;

   assign advance    = !out_valid_ff || rsp.ready;
   assign snap_ready = advance;

   // magnitude above 2^63-1, or above 2^63 for a negative value
   assign too_big = snap.magnitude[63] && (!snap.negative || (|snap.magnitude[62:0]));

   // pick the status by priority and apply the sign
   always_comb begin
      if (snap.malformed) begin
         status_in = dttc_pkg::STATUS_NOT_NUMBER;
      end else if (snap.overflow || too_big) begin
         status_in = dttc_pkg::STATUS_OVERFLOW;
      end else if (snap.negative && (|snap.magnitude) && reject_negative) begin
         status_in = dttc_pkg::STATUS_NEG_REJECTED;
      end else begin
         status_in = dttc_pkg::STATUS_OK;
      end
      if (status_in != dttc_pkg::STATUS_OK) begin
         cents_in = '0;
      end else if (snap.negative) begin
         cents_in = 64'd0 - snap.magnitude;
      end else begin
         cents_in = snap.magnitude;
      end
   end

   assign out_valid_in = advance ? snap_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the result until it is taken
   always_ff @(posedge clock) begin
      if (advance && snap_valid) begin
         cents_ff  <= cents_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.cents_value  = cents_ff;
   assign rsp.parse_status = status_ff;

endmodule

>>> rtl/core/decimal_text_to_cents_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_cents_core
// Streaming decimal text to signed cents, rounded half up on the third
// fraction digit, with malformed, overflow and negative status.
// ----------------------------------------------------------------------------
// Takes one request per clock while not stalled: a character, or an end marker
// that asks for the result. Characters update the running parse state through
// one multiply-by-ten-and-add on the integer part, which sets the rate. An end
// marker is captured in the snapshot register at the edge that accepts it, and
// the result register loads from the snapshot register once it is free or its
// result is taken; end markers may also arrive back to back. While one result
// waits in the result register, requests keep flowing; a second end marker then
// waits in the snapshot register and requests stall until the waiting result is
// taken. Write csr_wr_data to the reject-negative register only while idle.
module decimal_text_to_cents_core (
   input  logic       clock,
   input  logic       reset,
   dttc_req_if.sink   req_chan,
   dttc_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                    reject_ff, reject_in;
   logic                    snap_valid;
   logic                    snap_ready;
   dttc_pkg::dttc_snap_type snap;

   // reject-negative control register
   assign reject_in = csr_wr_en ? csr_wr_data : reject_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_ff <= 1'b0;
      end else begin
         reject_ff <= reject_in;
      end
   end

   dttc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .snap_ready (snap_ready),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   dttc_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .reject_negative (reject_ff),
      .snap_valid      (snap_valid),
      .snap            (snap),
      .snap_ready      (snap_ready),
      .rsp             (rsp_chan)
   );

   // an accepted end marker always lands in the snapshot slot
   a_end_loads_snap: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.end_marker) |=> snap_valid)
      else $error("end marker did not load a snapshot");

   // any error status carries a zero value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.parse_status != dttc_pkg::STATUS_OK)
      |-> (rsp_chan.cents_value == 64'sd0))
      else $error("error result with nonzero value");

   // negative rejection only under the reject-negative register
   a_neg_needs_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.parse_status == dttc_pkg::STATUS_NEG_REJECTED)
      |-> reject_ff)
      else $error("negative rejected while rejection is off");

   // a snapshot waiting on a stalled output blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (snap_valid && rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while the snapshot slot is stuck");

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for decimal_text_to_cents_core. Streams decimal text
// requests (directed corner cases, then random numbers, broken text and noise)
// through the request channel and compares every result against a cycle-free
// parser model kept inside the bench. Both channel sides idle at random, the
// result side is held off for a long stretch once, and the reject-negative
// register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // characters the parser cares about
   localparam logic [7:0] CH_0     = "0";
   localparam logic [7:0] CH_9     = "9";
   localparam logic [7:0] CH_PLUS  = "+";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_POINT = ".";

   // largest integer part that still fits in cents below 2^63
   localparam logic [63:0] WHOLE_LIMIT = 64'd92233720368547758;
   localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;

   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 8;

   typedef enum logic [2:0] {
      TXT_START,
      TXT_SIGNED,
      TXT_WHOLE,
      TXT_FRAC,
      TXT_BAD
   } text_phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } text_req_type;

   typedef struct packed {
      logic signed [63:0] cents;
      logic [1:0]         status;
   } cents_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   dttc_req_if req_chan ();
   dttc_rsp_if rsp_chan ();

   decimal_text_to_cents_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // pending requests and expected results
   text_req_type     text_req_q[$];
   cents_result_type expected_cents_q[$];

   // parser model state
   text_phase_type txt_phase;
   logic        txt_neg;
   logic [63:0] whole_acc;
   logic [6:0]  frac_cents;
   logic [1:0]  frac_cnt;
   logic [3:0]  round_digit;
   logic        whole_ovf;
   logic        neg_reject_cfg;

   // idling controls
   logic        send_burst;
   logic        rcv_burst;
   logic        rcv_hold;
   logic        holdoff_go;
   int unsigned send_gap;
   int unsigned rcv_stall;
   int unsigned pushed_items;
   int unsigned error_count;

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------
   function automatic void clear_text();
      txt_phase   = TXT_START;
      txt_neg     = 1'b0;
      whole_acc   = '0;
      frac_cents  = '0;
      frac_cnt    = '0;
      round_digit = '0;
      whole_ovf   = 1'b0;
   endfunction

   // advance the parse state by one character
   function automatic void absorb_char(input logic [7:0] c);
      logic        is_digit;
      logic [63:0] d;
      is_digit = (c >= CH_0) && (c <= CH_9);
      d = is_digit ? 64'(c - CH_0) : 64'd0;
      if (txt_phase == TXT_START && (c == CH_PLUS || c == CH_MINUS)) begin
         txt_neg   = (c == CH_MINUS);
         txt_phase = TXT_SIGNED;
      end else if (txt_phase inside {TXT_START, TXT_SIGNED, TXT_WHOLE}) begin
         if (is_digit) begin
            // flag overflow instead of wrapping the integer part
            if (whole_ovf || whole_acc > (WHOLE_LIMIT - d) / 64'd10)
               whole_ovf = 1'b1;
            else
               whole_acc = whole_acc * 64'd10 + d;
            txt_phase = TXT_WHOLE;
         end else if (c == CH_POINT && txt_phase == TXT_WHOLE) begin
            txt_phase = TXT_FRAC;
         end else begin
            txt_phase = TXT_BAD;
         end
      end else if (txt_phase == TXT_FRAC) begin
         if (!is_digit) begin
            txt_phase = TXT_BAD;
         end else if (frac_cnt < 2'd2) begin
            frac_cents = 7'(frac_cents * 7'd10 + d[6:0]);
            frac_cnt   = frac_cnt + 2'd1;
         end else if (frac_cnt == 2'd2) begin
            round_digit = d[3:0];
            frac_cnt    = 2'd3;
         end
      end
   endfunction

   // close the text: work out cents and status, then start over
   function automatic cents_result_type finish_text();
      cents_result_type res;
      logic [63:0]   mag;
      logic [63:0]   frac;
      logic [63:0]   lim;
      logic [1:0]    st;
      st  = dttc_pkg::STATUS_OK;
      mag = '0;
      if (txt_phase != TXT_WHOLE && txt_phase != TXT_FRAC) begin
         st = dttc_pkg::STATUS_NOT_NUMBER;
      end else begin
         case (frac_cnt)
            2'd0:    frac = 64'd0;
            2'd1:    frac = 64'(frac_cents) * 64'd10;
            default: frac = 64'(frac_cents);
         endcase
         mag = whole_acc * 64'd100 + frac;
         // round half up on the third fraction digit
         if (frac_cnt == 2'd3 && round_digit >= 4'd5)
            mag = mag + 64'd1;
         lim = txt_neg ? NEG_LIMIT : POS_LIMIT;
         if (whole_ovf || mag > lim)
            st = dttc_pkg::STATUS_OVERFLOW;
         else if (txt_neg && mag != 64'd0 && neg_reject_cfg)
            st = dttc_pkg::STATUS_NEG_REJECTED;
      end
      if (st != dttc_pkg::STATUS_OK)
         mag = '0;
      else if (txt_neg)
         mag = 64'd0 - mag;
      res.cents  = mag;
      res.status = st;
      clear_text();
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)      return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else             return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: present queued requests, predict on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      text_req_type nxt;
      logic      took;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         took = req_chan.valid && req_chan.ready;
         if (took) begin
            if (req_chan.end_marker)
               expected_cents_q.insert(expected_cents_q.size(), finish_text());
            else
               absorb_char(req_chan.text_char);
            send_gap = send_burst ? 0 : pick_gap();
         end
         // hold an offered request until it is taken
         if (req_chan.valid && !took) begin
         end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (text_req_q.size() > 0) begin
            nxt = text_req_q.pop_front();
            req_chan.text_char  <= nxt.ch;
            req_chan.end_marker <= nxt.fin;
            req_chan.valid      <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compare against the oldest expectation, stall at random
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      cents_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rcv_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_cents_q.size() == 0) begin
               $display("%0t: unexpected result: cents %0d status %0d", $time,
                        rsp_chan.cents_value, rsp_chan.parse_status);
               error_count++;
            end else begin
               want = expected_cents_q.pop_front();
               if (rsp_chan.cents_value !== want.cents) begin
                  $display("%0t: cents_value mismatch: expected %0d actual %0d", $time,
                           want.cents, rsp_chan.cents_value);
                  error_count++;
               end
               if (rsp_chan.parse_status !== want.status) begin
                  $display("%0t: parse_status mismatch: expected %0d actual %0d", $time,
                           want.status, rsp_chan.parse_status);
                  error_count++;
               end
            end
            if (!rcv_burst)
               rcv_stall = pick_gap();
         end else if (!rsp_chan.valid && !rcv_burst && rcv_stall == 0 &&
                      $urandom_range(0, 15) == 0) begin
            rcv_stall = pick_gap();
         end
         if (rcv_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (rcv_stall > 0) begin
            rcv_stall = rcv_stall - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // long hold-off of the result side, counted here
   initial begin
      rcv_hold = 1'b0;
      wait (holdoff_go);
      @(posedge clock);
      rcv_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rcv_hold <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      text_req_q.insert(text_req_q.size(), text_req_type'{ch: c, fin: 1'b0});
      pushed_items++;
   endtask

   // the character lane carries junk on an end marker
   task automatic push_end();
      text_req_q.insert(text_req_q.size(),
                        text_req_type'{ch: 8'($urandom_range(0, 255)), fin: 1'b1});
      pushed_items++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
      push_end();
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'(CH_0 + $urandom_range(0, 9));
   endfunction

   // well-formed number with random content
   function automatic void build_number(ref logic [7:0] body[$]);
      string caps[4] = '{"92233720368547758", "92233720368547757",
                         "92233720368547759", "922337203685477580"};
      string       cap;
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 3);
      if (r == 0) body.insert(body.size(), CH_PLUS);
      else if (r == 1) body.insert(body.size(), CH_MINUS);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         cap = caps[$urandom_range(0, 3)];
         for (int i = 0; i < cap.len(); i++)
            body.insert(body.size(), cap[i]);
      end else begin
         n = (r < 18) ? $urandom_range(15, 20) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            body.insert(body.size(), rand_digit());
      end
      if ($urandom_range(0, 3) != 0) begin
         body.insert(body.size(), CH_POINT);
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++)
            body.insert(body.size(), rand_digit());
      end
   endfunction

   task automatic push_random_text();
      logic [7:0]  body[$];
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         build_number(body);
      end else if (r < 88) begin
         // well-formed text with one possible defect
         build_number(body);
         case ($urandom_range(0, 3))
            0: body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
            1: body.insert($urandom_range(1, body.size()),
                           $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            2: body.insert($urandom_range(0, body.size()), CH_POINT);
            default: body.push_front(CH_POINT);
         endcase
      end else begin
         // raw noise, possibly empty
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++)
            body.insert(body.size(), 8'($urandom_range(0, 255)));
      end
      foreach (body[i])
         push_char(body[i]);
      // now and then run two texts together
      if ($urandom_range(0, 31) != 0)
         push_end();
   endtask

   // drain everything, then let the pipeline settle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (text_req_q.size() != 0 || req_chan.valid || expected_cents_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_neg_reject(input logic v);
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= v;
      neg_reject_cfg = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned phase_start;
      int unsigned batch_start;
      int          p;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.text_char   = '0;
      req_chan.end_marker  = 1'b0;
      rsp_chan.ready       = 1'b0;
      send_burst           = 1'b0;
      rcv_burst            = 1'b0;
      holdoff_go           = 1'b0;
      neg_reject_cfg       = 1'b0;
      pushed_items         = 0;
      error_count          = 0;
      clear_text();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners with negatives allowed
      write_neg_reject(1'b0);
      push_text("");
      push_text("+");
      push_text("-");
      push_text(".5");
      push_text("5.");
      push_text("0");
      push_text("-12.3");
      push_text("1.005");
      push_text("2.999");
      push_text("1.2.3");
      push_text("1-2");
      push_text("--1");
      push_char("5");
      push_char(8'hFF);
      push_end();
      push_text("92233720368547758.07");
      push_text("92233720368547758.08");
      push_text("-92233720368547758.08");
      push_text("-92233720368547758.085");
      push_text("92233720368547758.075");
      push_text("922337203685477580");
      push_text("99999999999999999999");
      push_text("-0.004");
      push_text("0.995");
      push_text("+1.239999");
      wait_idle();

      // directed corners with negatives rejected
      write_neg_reject(1'b1);
      push_text("-5");
      push_text("-0.00");
      push_text("-0.005");
      push_text("-92233720368547758.09");
      wait_idle();

      // fill the block while the result side holds off
      send_burst <= 1'b1;
      holdoff_go = 1'b1;
      @(posedge clock);
      for (int i = 0; i < 40; i++) begin
         push_char(rand_digit());
         if (i % 3 == 0) push_char(CH_POINT);
         push_end();
      end
      wait_idle();

      // random phases, register value and idling style change per phase
      phase_start = pushed_items;
      for (p = 0; pushed_items - phase_start < 850; p++) begin
         write_neg_reject((p % 3 == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
         send_burst <= (p % 4 == 1);
         rcv_burst  <= (p % 4 == 2);
         @(posedge clock);
         batch_start = pushed_items;
         while (pushed_items - batch_start < 150)
            push_random_text();
         wait_idle();
      end

      repeat (12) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
